// ===== rtl/bprs_pkg.sv =====
// ----------------------------------------------------------------------------
// bprs_pkg
// Shared types and constants for the binary patch result size block.
// ----------------------------------------------------------------------------
package bprs_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned STATUS_W     = 2;

  // header byte positions (count of bytes already taken in)
  localparam logic [CNT_W-1:0] CNT_START_LAST = 4'd3;   // last byte of start word
  localparam logic [CNT_W-1:0] CNT_START_DONE = 4'd4;   // start word complete
  localparam logic [CNT_W-1:0] CNT_END_LAST   = 4'd7;   // last byte of end word
  localparam logic [CNT_W-1:0] CNT_END_DONE   = 4'd8;   // end word complete
  localparam logic [CNT_W-1:0] CNT_LEN_LAST   = 4'd11;  // last byte of the header

  // item kinds on the input channel
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOP  = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_START_AFTER = 2'd1,
    ST_TRUNCATED   = 2'd2
  } status_t;

  // one input item as held in the input register
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] patch_byte;
  } item_t;

  // input stage to core handshake
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

// ===== rtl/bprs_in_stage.sv =====
// ----------------------------------------------------------------------------
// bprs_in_stage
// Input register: captures one item per cycle and holds it until the core
// takes it.
// ----------------------------------------------------------------------------
module bprs_in_stage
  import bprs_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  item_t  in_item,
  output stage_t stage,
  input  logic   core_ready
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // free slot, or the held item leaves this cycle
  assign in_ready = !valid_r || core_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (core_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// ===== rtl/bprs_core.sv =====
// ----------------------------------------------------------------------------
// bprs_core
// Hunk header parser, running size and result register.
// Keeps net = size - previous end, updated in single adds at three header
// positions, so the final size is one add with the original length.
// ----------------------------------------------------------------------------
module bprs_core
  import bprs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  stage_t            stage,
  output logic              core_ready,
  input  logic [WORD_W-1:0] orig_len,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_size,
  output status_t           out_status
);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] shift_r, shift_nxt;
  logic [WORD_W-1:0] start_r, start_nxt;
  logic [WORD_W-1:0] end_r, end_nxt;
  logic [WORD_W-1:0] skip_r, skip_nxt;
  logic [WORD_W-1:0] net_r, net_nxt;
  logic              err_r, err_nxt;
  logic              oval_r, oval_nxt;
  logic [WORD_W-1:0] osize_r, osize_nxt;
  status_t           ostat_r, ostat_nxt;
  logic              take;
  logic [WORD_W-1:0] shifted;

  // an end marker waits only while an unread result sits in the output reg
  assign core_ready = !(stage.item.kind == KIND_EOP && oval_r && !out_ready);
  assign take       = stage.valid && core_ready;
  assign shifted    = {shift_r[WORD_W-BYTE_W-1:0], stage.item.patch_byte};

  always_comb begin
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    skip_nxt  = skip_r;
    net_nxt   = net_r;
    err_nxt   = err_r;
    oval_nxt  = oval_r && !out_ready;
    osize_nxt = osize_r;
    ostat_nxt = ostat_r;

    if (take && stage.item.kind == KIND_BYTE) begin
      // patch byte: skip data, or shift in a header byte
      if (!err_r) begin
        if (skip_r != '0) begin
          skip_nxt = skip_r - 1'b1;
        end else begin
          shift_nxt = shifted;
          cnt_nxt   = cnt_r + 1'b1;
          case (cnt_r)
            CNT_START_LAST: start_nxt = shifted;
            CNT_START_DONE: net_nxt   = net_r + start_r;
            CNT_END_LAST:   end_nxt   = shifted;
            CNT_END_DONE:   net_nxt   = net_r - end_r;
            CNT_LEN_LAST: begin
              cnt_nxt = '0;
              if (start_r > end_r) begin
                err_nxt = 1'b1;
              end else begin
                net_nxt  = net_r + shifted;
                skip_nxt = shifted;
              end
            end
            default: ;
          endcase
        end
      end
    end else if (take) begin
      // end marker: report and clear
      oval_nxt = 1'b1;
      if (err_r) begin
        ostat_nxt = ST_START_AFTER;
        osize_nxt = '0;
      end else if (cnt_r != '0 || skip_r != '0) begin
        ostat_nxt = ST_TRUNCATED;
        osize_nxt = '0;
      end else begin
        ostat_nxt = ST_OK;
        osize_nxt = net_r + orig_len;
      end
      cnt_nxt   = '0;
      shift_nxt = '0;
      start_nxt = '0;
      end_nxt   = '0;
      skip_nxt  = '0;
      net_nxt   = '0;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      shift_r <= '0;
      start_r <= '0;
      end_r   <= '0;
      skip_r  <= '0;
      net_r   <= '0;
      err_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      skip_r  <= skip_nxt;
      net_r   <= net_nxt;
      err_r   <= err_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    osize_r <= osize_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_valid  = oval_r;
  assign out_size   = osize_r;
  assign out_status = ostat_r;

endmodule

// ===== rtl/binary_patch_result_size.sv =====
// An end marker passes the input register and then the core's result register.
// Throughput: one item per cycle; an end marker waits only while the
// previous result is still unread in the output register.
// Reset (rst_n low, synchronous): clears parse state, running size, pending
// result and the original length register.
// ----------------------------------------------------------------------------
// binary_patch_result_size
// Streams a binary delta patch byte by byte and reports the patched size.
// ----------------------------------------------------------------------------
module binary_patch_result_size
  import bprs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [BYTE_W-1:0]   in_tdata,    // [7:0] patch_byte
  input  logic                in_tuser,    // [0] kind
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [WORD_W-1:0]   out_tdata,   // [31:0] result_size
  output logic [STATUS_W-1:0] out_tuser,   // [1:0] status
  input  logic                cfg_wr_en,
  input  logic [WORD_W-1:0]   cfg_wr_data  // original_length
);

  logic [WORD_W-1:0] orig_len_r;
  item_t             in_item;
  stage_t            stage;
  logic              core_ready;
  status_t           out_status;

  // original length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orig_len_r <= '0;
    end else if (cfg_wr_en) begin
      orig_len_r <= cfg_wr_data;
    end
  end

  assign in_item.kind       = in_tuser;
  assign in_item.patch_byte = in_tdata;

  bprs_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .stage      (stage),
    .core_ready (core_ready)
  );

  bprs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .core_ready (core_ready),
    .orig_len   (orig_len_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_size   (out_tdata),
    .out_status (out_status)
  );

  assign out_tuser = out_status;

endmodule

// ===== rtl/bprs_chk.sv =====
// ----------------------------------------------------------------------------
// bprs_chk
// Port-level checks for binary_patch_result_size, bound to the top level.
// ----------------------------------------------------------------------------
module bprs_chk
  import bprs_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [WORD_W-1:0]   out_tdata,
  input logic [STATUS_W-1:0] out_tuser
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // after reset nothing is pending and input is open
  a_reset_idle: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // error results carry zero size
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("nonzero size with error status");

  // unused status code never shows
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == ST_OK || out_tuser == ST_START_AFTER ||
                   out_tuser == ST_TRUNCATED)
    else $error("bad status code");

endmodule

bind binary_patch_result_size bprs_chk u_bprs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
